FILE: sv/lcss_pkg.sv
// Shared types, constants and helper functions of the LBA to CHS sector splitter.
// Used by the channel interfaces and by every module of the block; depends on nothing.
package lcss_pkg;

   localparam int ADDR_W      = 32;   // block numbers, positions, quotients
   localparam int LEN_W       = 15;   // request length in bytes
   localparam int OFFS_W      = 12;   // byte offset inside a sector, widest sector size
   localparam int SPT_W       = 6;
   localparam int HEADS_W     = 9;
   localparam int DRIVE_W     = 8;
   localparam int CYL_W       = 16;
   localparam int HEAD_W      = 8;
   localparam int BUF_OFFS_W  = 15;
   localparam int BYTES_W     = 10;

   localparam int SECTOR_BYTES_DEF  = 512;
   localparam int CHUNK_SECTORS_DEF = 8;
   localparam int MAX_SEGMENTS_DEF  = 64;
   localparam int QUEUE_DEPTH_DEF   = 2;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_SPT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEADS = 1'd1;

   localparam logic [SPT_W-1:0]   SPT_RESET   = 6'd63;
   localparam logic [HEADS_W-1:0] HEADS_RESET = 9'd16;
   localparam logic [HEADS_W-1:0] HEADS_MAX   = 9'd256;

   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_ERROR   = 1'b1;

   typedef struct packed {
      logic [SPT_W-1:0]   spt;
      logic [HEADS_W-1:0] heads;
   } geom_type;

   typedef struct packed {
      logic               is_error;
      logic [DRIVE_W-1:0] drive;
      logic [ADDR_W-1:0]  first;
      logic [OFFS_W-1:0]  boffs;
      logic [LEN_W-1:0]   length;
      logic [ADDR_W-1:0]  new_position;
   } job_type;

   typedef struct packed {
      logic                  kind;
      logic [CYL_W-1:0]      cylinder;
      logic [HEAD_W-1:0]     head;
      logic [SPT_W-1:0]      sector;
      logic                  refill;
      logic [SPT_W-1:0]      refill_start;
      logic [SPT_W-1:0]      refill_count;
      logic [BUF_OFFS_W-1:0] buffer_offset;
      logic [BYTES_W-1:0]    byte_count;
      logic [ADDR_W-1:0]     new_position;
      logic                  cylinder_overflow;
      logic                  last;
   } rsp_type;

   // Largest multiple of the chunk size that does not exceed the zero-based sector.
   function automatic logic [SPT_W-1:0] chunk_base(input logic [SPT_W-1:0] sec0,
                                                   input int chunk);
      logic [SPT_W-1:0] base;
      base = '0;
      for (int j = 0; j < 64; j++) begin
         if (j * chunk <= int'(sec0)) begin
            base = SPT_W'(j * chunk);
         end
      end
      return base;
   endfunction

endpackage

FILE: sv/lcss_req_if.sv
// Request channel of the sector splitter: valid/ready handshake and request fields.
// Depends on lcss_pkg for the field widths.
interface lcss_req_if;
   import lcss_pkg::*;

   logic               valid;
   logic               ready;
   logic [DRIVE_W-1:0] drive;
   logic [ADDR_W-1:0]  start_block;
   logic [ADDR_W-1:0]  position;
   logic [LEN_W-1:0]   length;

   modport source (output valid, output drive, output start_block, output position,
                   output length, input ready);
   modport sink   (input valid, input drive, input start_block, input position,
                   input length, output ready);
endinterface

FILE: sv/lcss_rsp_if.sv
// Response channel of the sector splitter: valid/ready handshake and segment fields.
// Depends on lcss_pkg for the field widths.
interface lcss_rsp_if;
   import lcss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [CYL_W-1:0]      cylinder;
   logic [HEAD_W-1:0]     head;
   logic [SPT_W-1:0]      sector;
   logic                  refill;
   logic [SPT_W-1:0]      refill_start;
   logic [SPT_W-1:0]      refill_count;
   logic [BUF_OFFS_W-1:0] buffer_offset;
   logic [BYTES_W-1:0]    byte_count;
   logic [ADDR_W-1:0]     new_position;
   logic                  cylinder_overflow;
   logic                  last;

   modport source (output valid, output kind, output cylinder, output head, output sector,
                   output refill, output refill_start, output refill_count,
                   output buffer_offset, output byte_count, output new_position,
                   output cylinder_overflow, output last, input ready);
   modport sink   (input valid, input kind, input cylinder, input head, input sector,
                   input refill, input refill_start, input refill_count,
                   input buffer_offset, input byte_count, input new_position,
                   input cylinder_overflow, input last, output ready);
endinterface

FILE: sv/lcss_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on lcss_pkg for the dividend width.
module lcss_divider #(
   parameter int DIVISOR_W = 9
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [lcss_pkg::ADDR_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]        divisor,
   output logic                        done,
   output logic [lcss_pkg::ADDR_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]        remainder
);
   import lcss_pkg::*;

   localparam int CNT_W = $clog2(ADDR_W);

   logic                 busy_ff;
   logic                 done_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [ADDR_W-1:0]    quo_ff;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] dsr_ff;

   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   diff;
   logic                 fits;

   // The partial remainder stays below the divisor, so the trial fits one extra bit.
   assign trial = {rem_ff, quo_ff[ADDR_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(ADDR_W - 1);
         end else if (busy_ff) begin
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               count_ff <= count_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[ADDR_W-2:0], fits};
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/lcss_queue.sv
// Short job queue between the request front end and the segment back end.
// Depends on lcss_pkg for the job type.
module lcss_queue #(
   parameter int DEPTH = lcss_pkg::QUEUE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lcss_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output lcss_pkg::job_type pop_job,
   output logic              empty
);
   import lcss_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   job_type         mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] ptr);
      return (ptr == PW'(DEPTH - 1)) ? '0 : ptr + PW'(1);
   endfunction

   assign full    = count_ff == CW'(DEPTH);
   assign empty   = count_ff == '0;
   assign pop_job = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

FILE: sv/lcss_front.sv
// Request front end: takes a request, splits the position into block and byte offset,
// and queues a job. Depends on lcss_pkg and lcss_req_if.
module lcss_front #(
   parameter int SECTOR_BYTES = lcss_pkg::SECTOR_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   lcss_req_if.sink          req,
   output logic              push,
   output lcss_pkg::job_type push_job,
   input  logic              full
);
   import lcss_pkg::*;

   // The sector size is a power of two, so the split is a shift and a mask.
   localparam int SB_LOG = $clog2(SECTOR_BYTES);

   typedef enum logic [1:0] {
      FS_IDLE = 2'b01,
      FS_PUSH = 2'b10
   } front_state_type;

   front_state_type    state_ff, state_in;
   logic [DRIVE_W-1:0] drive_ff;
   logic [ADDR_W-1:0]  start_ff;
   logic [ADDR_W-1:0]  pos_ff;
   logic [LEN_W-1:0]   len_ff;

   logic               accept;
   logic [ADDR_W-1:0]  pos_blocks;
   logic [OFFS_W-1:0]  pos_bytes;

   assign req.ready = state_ff == FS_IDLE;
   assign accept    = req.valid && req.ready;

   assign pos_blocks = pos_ff >> SB_LOG;
   assign pos_bytes  = OFFS_W'(pos_ff & ADDR_W'(SECTOR_BYTES - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            if (!full) begin
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         drive_ff <= req.drive;
         start_ff <= req.start_block;
         pos_ff   <= req.position;
         len_ff   <= req.length;
      end
   end

   assign push                  = (state_ff == FS_PUSH) && !full;
   assign push_job.is_error     = len_ff == '0;
   assign push_job.drive        = drive_ff;
   assign push_job.first        = start_ff + pos_blocks;
   assign push_job.boffs        = pos_bytes;
   assign push_job.length       = len_ff;
   assign push_job.new_position = pos_ff + ADDR_W'(len_ff);

endmodule

FILE: sv/lcss_back.sv
// Segment back end: walks the sectors of a job, translates each block to CHS through a
// shared divider, checks the chunk tag and drives the response register.
// Depends on lcss_pkg, lcss_rsp_if and lcss_divider.
module lcss_back #(
   parameter int SECTOR_BYTES  = lcss_pkg::SECTOR_BYTES_DEF,
   parameter int CHUNK_SECTORS = lcss_pkg::CHUNK_SECTORS_DEF,
   parameter int MAX_SEGMENTS  = lcss_pkg::MAX_SEGMENTS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  lcss_pkg::geom_type geom,
   output logic               pop,
   input  lcss_pkg::job_type  pop_job,
   input  logic               empty,
   lcss_rsp_if.source         rsp
);
   import lcss_pkg::*;

   localparam int KW = $clog2(MAX_SEGMENTS + 1);

   typedef enum logic [3:0] {
      BS_IDLE      = 4'b0001,
      BS_DIV_SPT   = 4'b0010,
      BS_DIV_HEADS = 4'b0100,
      BS_EMIT      = 4'b1000
   } back_state_type;

   back_state_type       state_ff, state_in;
   job_type              job_ff;
   logic [ADDR_W-1:0]    blk_ff;
   logic [LEN_W-1:0]     remaining_ff;
   logic [OFFS_W-1:0]    segoff_ff;
   logic [KW-1:0]        k_ff;
   logic [SPT_W-1:0]     sec0_ff;

   logic                 tag_valid_ff;
   logic [DRIVE_W-1:0]   tag_drive_ff;
   logic [CYL_W-1:0]     tag_cyl_ff;
   logic [HEAD_W-1:0]    tag_head_ff;
   logic [SPT_W-1:0]     tag_chunk_ff;

   rsp_type              out_ff;
   logic                 out_valid_ff;

   logic                 div_start;
   logic [ADDR_W-1:0]    div_dividend;
   logic [HEADS_W-1:0]   div_divisor;
   logic                 div_done;
   logic [ADDR_W-1:0]    div_quo;
   logic [HEADS_W-1:0]   div_rem;

   logic                 slot_free;
   logic                 load_out;
   logic [SPT_W-1:0]     base;
   logic [SPT_W-1:0]     chunk;
   logic [SPT_W-1:0]     chunk_rem;
   logic [CYL_W-1:0]     c16;
   logic [HEAD_W-1:0]    h8;
   logic                 refill;
   logic [15:0]          room16;
   logic [15:0]          rem16;
   logic [15:0]          bytes16;
   logic                 seg_last;
   logic [19:0]          offset20;
   logic [SPT_W-1:0]     refill_count;
   rsp_type              result;

   lcss_divider #(.DIVISOR_W(HEADS_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign slot_free = !out_valid_ff || rsp.ready;
   assign pop       = (state_ff == BS_IDLE) && !empty;
   assign load_out  = (state_ff == BS_EMIT) && slot_free;

   // After the second division the divider holds cylinder and head.
   always_comb begin
      base      = chunk_base(sec0_ff, CHUNK_SECTORS);
      chunk     = base + SPT_W'(1);
      chunk_rem = sec0_ff - base;
      c16       = div_quo[CYL_W-1:0];
      h8        = div_rem[HEAD_W-1:0];
      refill    = !tag_valid_ff || (job_ff.drive != tag_drive_ff) || (c16 != tag_cyl_ff) ||
                  (h8 != tag_head_ff) || (chunk != tag_chunk_ff);
      room16    = 16'(SECTOR_BYTES) - 16'(segoff_ff);
      rem16     = 16'(remaining_ff);
      bytes16   = (rem16 < room16) ? rem16 : room16;
      seg_last  = (rem16 <= room16) || (k_ff == KW'(MAX_SEGMENTS - 1));
      offset20  = 20'(chunk_rem) * 20'(SECTOR_BYTES) + 20'(segoff_ff);
      refill_count = (SPT_W'(CHUNK_SECTORS) < geom.spt) ? SPT_W'(CHUNK_SECTORS) : geom.spt;

      result = '0;
      if (job_ff.is_error) begin
         result.kind = KIND_ERROR;
         result.last = 1'b1;
      end else begin
         result.kind              = KIND_SEGMENT;
         result.cylinder          = c16;
         result.head              = h8;
         result.sector            = sec0_ff + SPT_W'(1);
         result.refill            = refill;
         result.refill_start      = chunk;
         result.refill_count      = refill_count;
         result.buffer_offset     = offset20[BUF_OFFS_W-1:0];
         result.byte_count        = bytes16[BYTES_W-1:0];
         result.new_position      = seg_last ? job_ff.new_position : '0;
         result.cylinder_overflow = div_quo[ADDR_W-1:CYL_W] != '0;
         result.last              = seg_last;
      end
   end

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = blk_ff;
      div_divisor  = HEADS_W'(geom.spt);
      case (state_ff)
         BS_IDLE: begin
            if (!empty) begin
               if (pop_job.is_error) begin
                  state_in = BS_EMIT;
               end else begin
                  state_in     = BS_DIV_SPT;
                  div_start    = 1'b1;
                  div_dividend = pop_job.first;
               end
            end
         end
         BS_DIV_SPT: begin
            if (div_done) begin
               state_in     = BS_DIV_HEADS;
               div_start    = 1'b1;
               div_dividend = div_quo;
               div_divisor  = geom.heads;
            end
         end
         BS_DIV_HEADS: begin
            if (div_done) begin
               state_in = BS_EMIT;
            end
         end
         BS_EMIT: begin
            if (slot_free) begin
               if (job_ff.is_error || seg_last) begin
                  state_in = BS_IDLE;
               end else begin
                  state_in     = BS_DIV_SPT;
                  div_start    = 1'b1;
                  div_dividend = blk_ff + ADDR_W'(1);
               end
            end
         end
         default: state_in = BS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         out_valid_ff <= 1'b0;
         tag_valid_ff <= 1'b0;
         tag_drive_ff <= '1;
         tag_cyl_ff   <= '0;
         tag_head_ff  <= '0;
         tag_chunk_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (load_out && !job_ff.is_error && refill) begin
            tag_valid_ff <= 1'b1;
            tag_drive_ff <= job_ff.drive;
            tag_cyl_ff   <= c16;
            tag_head_ff  <= h8;
            tag_chunk_ff <= chunk;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff       <= pop_job;
         blk_ff       <= pop_job.first;
         remaining_ff <= pop_job.length;
         segoff_ff    <= pop_job.boffs;
         k_ff         <= '0;
      end else if (load_out && !job_ff.is_error && !seg_last) begin
         blk_ff       <= blk_ff + ADDR_W'(1);
         remaining_ff <= remaining_ff - bytes16[LEN_W-1:0];
         segoff_ff    <= '0;
         k_ff         <= k_ff + KW'(1);
      end
      if ((state_ff == BS_DIV_SPT) && div_done) begin
         sec0_ff <= div_rem[SPT_W-1:0];
      end
      if (load_out) begin
         out_ff <= result;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.kind              = out_ff.kind;
   assign rsp.cylinder          = out_ff.cylinder;
   assign rsp.head              = out_ff.head;
   assign rsp.sector            = out_ff.sector;
   assign rsp.refill            = out_ff.refill;
   assign rsp.refill_start      = out_ff.refill_start;
   assign rsp.refill_count      = out_ff.refill_count;
   assign rsp.buffer_offset     = out_ff.buffer_offset;
   assign rsp.byte_count        = out_ff.byte_count;
   assign rsp.new_position      = out_ff.new_position;
   assign rsp.cylinder_overflow = out_ff.cylinder_overflow;
   assign rsp.last              = out_ff.last;

`ifndef NO_ASSERTIONS
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_ff.kind == KIND_ERROR)) |-> out_ff.last)
      else $error("error transaction without last");

   a_segment_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BS_IDLE) |-> (k_ff <= KW'(MAX_SEGMENTS - 1)))
      else $error("segment counter ran past the segment limit");

   a_bytes_left: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == BS_EMIT) && !job_ff.is_error) |-> (remaining_ff != '0))
      else $error("segment emitted with no bytes left in the request");

   a_tag_loaded: assert property (@(posedge clock) disable iff (reset)
      (load_out && !job_ff.is_error) |=> tag_valid_ff)
      else $error("chunk tag not valid after a segment transaction");
`endif

endmodule

FILE: sv/lba_to_chs_sector_splitter.sv
// LBA to CHS sector splitter, top level.
// Requests (drive, start block, byte position, length) arrive on the req_ch channel and are
// accepted on a valid/ready transaction. Each request yields one response transaction per
// sector it spans on rsp_ch, up to the segment limit, with last set on the final one; a
// zero length yields a single error transaction. Each segment transaction carries the
// cylinder, head and sector, the chunk buffer offset and byte count, and whether the
// sector's chunk misses the one-entry tag and must be fetched first.
// Geometry is written through csr_we/csr_index/csr_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this. The front end registers an
// accepted request and, once the two-entry queue has room, pushes it as a job, so it takes
// the next request while the back end still works. The back end runs two divisions per
// sector on one shared divider, by sectors per track, then by heads; error jobs skip both.
// The response register holds a transaction while rsp_ch.ready is low; the back end then
// waits, and the front end stalls only once the queue is full.
// Synchronous reset empties the queue and the response register, clears the chunk tag and
// loads the default geometry of 63 sectors per track and 16 heads.
// Depends on lcss_pkg, the channel interfaces, lcss_front, lcss_queue and lcss_back.
module lba_to_chs_sector_splitter #(
   parameter int SECTOR_BYTES  = lcss_pkg::SECTOR_BYTES_DEF,
   parameter int CHUNK_SECTORS = lcss_pkg::CHUNK_SECTORS_DEF,
   parameter int MAX_SEGMENTS  = lcss_pkg::MAX_SEGMENTS_DEF,
   parameter int QUEUE_DEPTH   = lcss_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   lcss_req_if.sink                        req_ch,
   lcss_rsp_if.source                      rsp_ch,
   input  logic                            csr_we,
   input  logic [lcss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lcss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lcss_pkg::*;

   logic [SPT_W-1:0]   spt_ff;
   logic [HEADS_W-1:0] heads_ff;
   geom_type           geom;

   logic               push;
   job_type            push_job;
   logic               full;
   logic               pop;
   job_type            pop_job;
   logic               empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff   <= SPT_RESET;
         heads_ff <= HEADS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPT:   spt_ff   <= csr_wdata[SPT_W-1:0];
            CSR_HEADS: heads_ff <= csr_wdata[HEADS_W-1:0];
            default:   ;
         endcase
      end
   end

   // A zero geometry value acts as one, and the head count saturates at 256.
   always_comb begin
      geom.spt = (spt_ff == '0) ? SPT_W'(1) : spt_ff;
      if (heads_ff == '0) begin
         geom.heads = HEADS_W'(1);
      end else if (heads_ff > HEADS_MAX) begin
         geom.heads = HEADS_MAX;
      end else begin
         geom.heads = heads_ff;
      end
   end

   lcss_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .push     (push),
      .push_job (push_job),
      .full     (full)
   );

   lcss_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   lcss_back #(
      .SECTOR_BYTES  (SECTOR_BYTES),
      .CHUNK_SECTORS (CHUNK_SECTORS),
      .MAX_SEGMENTS  (MAX_SEGMENTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .geom    (geom),
      .pop     (pop),
      .pop_job (pop_job),
      .empty   (empty),
      .rsp     (rsp_ch)
   );

endmodule

FILE: sim/lba_to_chs_sector_splitter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench of the LBA to CHS sector splitter: directed and random read requests,
// each response transaction checked field by field against an in-bench geometry and tag predictor.
// Depends on lcss_pkg, lcss_req_if, lcss_rsp_if and lba_to_chs_sector_splitter.
module lba_to_chs_sector_splitter_test;
   import lcss_pkg::*;

   localparam int SEC_BYTES     = SECTOR_BYTES_DEF;
   localparam int CHUNK_SECS    = CHUNK_SECTORS_DEF;
   localparam int SEG_LIMIT     = MAX_SEGMENTS_DEF;
   localparam int MAX_GAP       = 17;
   localparam int SETTLE_CYCLES = 300;
   localparam longint CYCLE_LIMIT = 10_000_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   lcss_req_if req_bus ();
   lcss_rsp_if rsp_bus ();

   lba_to_chs_sector_splitter u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Geometry registers and chunk tag as the block should hold them.
   logic [SPT_W-1:0]   geom_spt;
   logic [HEADS_W-1:0] geom_heads;
   logic               tag_valid;
   logic [DRIVE_W-1:0] tag_drive;
   logic [CYL_W-1:0]   tag_cylinder;
   logic [HEAD_W-1:0]  tag_head;
   logic [SPT_W-1:0]   tag_chunk_start;

   rsp_type pending_segments[$];
   int      error_count = 0;
   int      segment_count = 0;
   longint  cycle_count = 0;
   bit      steady_flow = 1'b0;

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d segments pending", cycle_count,
                  pending_segments.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int draw_gap();
      if (steady_flow || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, MAX_GAP);
   endfunction

   // Splits one request into the segments the block must return and updates the chunk tag.
   function automatic void predict_segments(input logic [DRIVE_W-1:0] drive,
                                            input logic [ADDR_W-1:0]  start_block,
                                            input logic [ADDR_W-1:0]  position,
                                            input logic [LEN_W-1:0]   length);
      rsp_type     seg;
      int unsigned spt, heads, boffs, endoff, nsec, first, blk, quot, cyl, hd, sec;
      int unsigned chunk, segoff, bytes;
      logic        refill;
      spt   = (geom_spt == 0) ? 1 : geom_spt;
      heads = (geom_heads == 0) ? 1 : ((geom_heads > HEADS_MAX) ? HEADS_MAX : geom_heads);
      if (length == 0) begin
         seg = '0;
         seg.kind = KIND_ERROR;
         seg.last = 1'b1;
         pending_segments.push_back(seg);
         return;
      end
      boffs  = position % SEC_BYTES;
      endoff = boffs + length - 1;
      nsec   = endoff / SEC_BYTES + 1;
      if (nsec > SEG_LIMIT) nsec = SEG_LIMIT;
      first  = start_block + position / SEC_BYTES;
      for (int unsigned k = 0; k < nsec; k++) begin
         blk    = first + k;
         quot   = blk / spt;
         cyl    = quot / heads;
         hd     = quot % heads;
         sec    = blk % spt + 1;
         chunk  = (1 + ((sec - 1) / CHUNK_SECS) * CHUNK_SECS) & 'h3F;
         segoff = (k == 0) ? boffs : 0;
         refill = !tag_valid || drive != tag_drive || CYL_W'(cyl) != tag_cylinder ||
                  HEAD_W'(hd) != tag_head || SPT_W'(chunk) != tag_chunk_start;
         if (refill) begin
            tag_valid       = 1'b1;
            tag_drive       = drive;
            tag_cylinder    = CYL_W'(cyl);
            tag_head        = HEAD_W'(hd);
            tag_chunk_start = SPT_W'(chunk);
         end
         if (k == endoff / SEC_BYTES) bytes = endoff % SEC_BYTES + 1 - segoff;
         else bytes = SEC_BYTES - segoff;
         seg = '0;
         seg.kind              = KIND_SEGMENT;
         seg.cylinder          = CYL_W'(cyl);
         seg.head              = HEAD_W'(hd);
         seg.sector            = SPT_W'(sec);
         seg.refill            = refill;
         seg.refill_start      = SPT_W'(chunk);
         seg.refill_count      = SPT_W'((spt < CHUNK_SECS) ? spt : CHUNK_SECS);
         seg.buffer_offset     = BUF_OFFS_W'(((sec - 1) % CHUNK_SECS) * SEC_BYTES + segoff);
         seg.byte_count        = BYTES_W'(bytes);
         seg.last              = (k + 1 == nsec);
         seg.new_position      = seg.last ? position + ADDR_W'(length) : '0;
         seg.cylinder_overflow = (cyl > 32'hFFFF);
         pending_segments.push_back(seg);
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 100)
         $display("Mismatch on response %0d at cycle %0d: %s got 0x%0h, expected 0x%0h",
                  segment_count, cycle_count, what, got, want);
   endtask

   task automatic compare_field(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic check_segment();
      rsp_type want;
      segment_count++;
      if (pending_segments.size() == 0) begin
         report_mismatch("transaction with nothing pending, sector", 32'(rsp_bus.sector), '0);
         return;
      end
      want = pending_segments.pop_front();
      compare_field("kind", 32'(rsp_bus.kind), 32'(want.kind));
      compare_field("cylinder", 32'(rsp_bus.cylinder), 32'(want.cylinder));
      compare_field("head", 32'(rsp_bus.head), 32'(want.head));
      compare_field("sector", 32'(rsp_bus.sector), 32'(want.sector));
      compare_field("refill", 32'(rsp_bus.refill), 32'(want.refill));
      compare_field("refill_start", 32'(rsp_bus.refill_start), 32'(want.refill_start));
      compare_field("refill_count", 32'(rsp_bus.refill_count), 32'(want.refill_count));
      compare_field("buffer_offset", 32'(rsp_bus.buffer_offset), 32'(want.buffer_offset));
      compare_field("byte_count", 32'(rsp_bus.byte_count), 32'(want.byte_count));
      compare_field("new_position", rsp_bus.new_position, want.new_position);
      compare_field("cylinder_overflow", 32'(rsp_bus.cylinder_overflow),
                    32'(want.cylinder_overflow));
      compare_field("last", 32'(rsp_bus.last), 32'(want.last));
   endtask

   // Response side: stalls a random number of cycles before each transaction.
   initial begin : rsp_sink
      int stall;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         check_segment();
      end
   end

   // Valid is left high after a transaction; the next call either lowers it or keeps it
   // high with new fields, so it never gets two assignments in one step.
   task automatic send_request(input logic [DRIVE_W-1:0] drive,
                               input logic [ADDR_W-1:0]  start_block,
                               input logic [ADDR_W-1:0]  position,
                               input logic [LEN_W-1:0]   length);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.drive       <= drive;
      req_bus.start_block <= start_block;
      req_bus.position    <= position;
      req_bus.length      <= length;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_segments(drive, start_block, position, length);
   endtask

   task automatic wait_drained();
      while (pending_segments.size() != 0) @(posedge clock);
   endtask

   // Geometry is only written once every pending segment has come back.
   task automatic set_geometry(input logic [SPT_W-1:0] spt, input logic [HEADS_W-1:0] heads);
      logic [CSR_DATA_W-1:0] spt_word;
      req_bus.valid <= 1'b0;
      wait_drained();
      spt_word = CSR_DATA_W'($urandom);
      spt_word[SPT_W-1:0] = spt;
      csr_we    <= 1'b1;
      csr_index <= CSR_SPT;
      csr_wdata <= spt_word;
      @(posedge clock);
      geom_spt = spt;
      csr_index <= CSR_HEADS;
      csr_wdata <= heads;
      @(posedge clock);
      geom_heads = heads;
      csr_we <= 1'b0;
   endtask

   function automatic logic [LEN_W-1:0] draw_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return LEN_W'($urandom_range(1, 600));
      if (pick < 85) return LEN_W'($urandom_range(1, 4096));
      if (pick < 95) return LEN_W'($urandom_range(4097, 16383));
      return LEN_W'($urandom_range(16384, 32767));
   endfunction

   function automatic logic [ADDR_W-1:0] draw_block();
      case ($urandom_range(0, 3))
         0: return 32'hFFFF_FF00 + $urandom_range(0, 255);
         1: return $urandom_range(0, 1_000_000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SPT_W-1:0] draw_spt();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 6'd1;
         2: return 6'd63;
         default: return SPT_W'($urandom_range(1, 63));
      endcase
   endfunction

   function automatic logic [HEADS_W-1:0] draw_heads();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 9'd1;
         2: return HEADS_MAX;
         3: return HEADS_W'($urandom_range(257, 511));
         default: return HEADS_W'($urandom_range(1, 256));
      endcase
   endfunction

   task automatic test_zero_length();
      send_request(8'h00, 32'h0000_0000, 32'h0000_0000, 15'd0);
      send_request(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd0);
   endtask

   task automatic test_field_extremes();
      set_geometry(SPT_RESET, HEADS_RESET);
      send_request(8'h00, 32'h0000_0000, 32'h0000_0000, 15'd1);
      // Too many sectors, the block number and the new position both wrap.
      send_request(8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF);
      send_request(8'h00, 32'hFFFF_FFFF, 32'h0000_0000, 15'd600);
      send_request(8'h07, 32'd100, 32'd511, 15'd2);
      // The same chunk again, so the tag should hit.
      send_request(8'h07, 32'd100, 32'd1024, 15'd512);
      send_request(8'h07, 32'd100, 32'd1024, 15'd512);
      send_request(8'h00, 32'h0000_0000, 32'h0000_0000, 15'd32257);
      send_request(8'h5A, 32'h8000_0000, 32'h1234_5678, 15'h5555);
      send_request(8'hA5, 32'h7FFF_FFFF, 32'hEDCB_A987, 15'h2AAA);
   endtask

   task automatic test_geometry_extremes();
      set_geometry(6'd63, HEADS_MAX);
      send_request(8'h01, 32'hFFFF_FFF0, 32'd0, 15'd8192);
      set_geometry(6'd1, 9'd1);
      // Cylinders run past 65535 here.
      send_request(8'h02, 32'h0000_FFFE, 32'd100, 15'd1500);
      set_geometry(6'd0, 9'd0);
      send_request(8'h02, 32'h0000_FFFE, 32'd100, 15'd1500);
      set_geometry(6'd5, 9'd511);
      send_request(8'h03, 32'd1234, 32'd2048, 15'd3000);
      send_request(8'h03, 32'd1234, 32'd5048, 15'd512);
      set_geometry(6'd17, 9'd257);
      send_request(8'h04, 32'h8000_0000, 32'h0000_0100, 15'd700);
   endtask

   // Mostly sequential reads through one file, so that consecutive requests share chunks,
   // mixed with requests whose fields are all random.
   task automatic test_random_traffic(input int item_total);
      int                 sent;
      int                 burst;
      logic [DRIVE_W-1:0] drive;
      logic [ADDR_W-1:0]  start_block;
      logic [ADDR_W-1:0]  position;
      logic [LEN_W-1:0]   length;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(0, 9) < 7) begin
            drive       = DRIVE_W'($urandom);
            start_block = draw_block();
            position    = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 65535);
            burst       = $urandom_range(2, 8);
            repeat (burst) begin
               length = draw_length();
               send_request(drive, start_block, position, length);
               if ($urandom_range(0, 4) != 0) position = position + ADDR_W'(length);
               sent++;
            end
         end else begin
            length = ($urandom_range(0, 9) == 0) ? '0 : draw_length();
            send_request(DRIVE_W'($urandom), $urandom, $urandom, length);
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      req_bus.valid       = 1'b0;
      req_bus.drive       = '0;
      req_bus.start_block = '0;
      req_bus.position    = '0;
      req_bus.length      = '0;
      geom_spt        = SPT_RESET;
      geom_heads      = HEADS_RESET;
      tag_valid       = 1'b0;
      tag_drive       = '1;
      tag_cylinder    = '0;
      tag_head        = '0;
      tag_chunk_start = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_zero_length();
      test_field_extremes();
      test_geometry_extremes();
      for (int phase = 0; phase < 8; phase++) begin
         steady_flow = (phase == 3);
         set_geometry(draw_spt(), draw_heads());
         test_random_traffic(50);
      end

      req_bus.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/lcss_pkg.sv
sv/lcss_req_if.sv
sv/lcss_rsp_if.sv
sv/lcss_divider.sv
sv/lcss_queue.sv
sv/lcss_front.sv
sv/lcss_back.sv
sv/lba_to_chs_sector_splitter.sv
sim/lba_to_chs_sector_splitter_test.sv
